/* sv/memw_pkg.sv */
// ----------------------------------------------------------------------------
// memw_pkg
// Types and fixed widths shared by the minimum-energy window weight unit.
// ----------------------------------------------------------------------------
`default_nettype none

package memw_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 22;
  localparam int NRG_W      = 36;
  localparam int TOT_W      = 27;
  localparam int SEEN_W     = 11;
  localparam int PROD_W     = 47;
  localparam int LEN_W      = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [LEN_W-1:0]  WINDOW_LEN_RESET = 6'd10;
  localparam logic [SEEN_W-1:0] SEEN_MAX         = '1;

  localparam logic signed [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
  localparam logic signed [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

  localparam logic signed [PROD_W-1:0] PROD_MAX = {1'b0, {(PROD_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] PROD_MIN = {1'b1, {(PROD_W-1){1'b0}}};

  // register word index (byte address bits above the word offset)
  localparam logic [CFG_ADDR_W-3:0] REG_WINDOW_LEN = '0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } memw_in_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] weighted_total;
    logic                     window_found;
    logic                     sum_saturated;
  } memw_out_t;

  // window result handed from the prefix bank to the best-window tracker
  typedef struct packed {
    logic                    vld;
    logic                    last;
    logic                    full;
    logic signed [TOT_W-1:0] total;
    logic                    clipped;
    logic signed [SUM_W-1:0] win_sum;
    logic [NRG_W-1:0]        win_energy;
  } memw_win_t;

endpackage

`default_nettype wire

/* sv/memw_cfg.sv */
// ----------------------------------------------------------------------------
// memw_cfg
// APB-style register port holding the window length; clamps it for use.
// ----------------------------------------------------------------------------
`default_nettype none

module memw_cfg import memw_pkg::*; #(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output logic      [LEN_W-1:0]      len_eff
);

  logic [LEN_W-1:0] window_len_r;
  logic             sel_len;

  assign sel_len    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LEN);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_LEN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_len) begin
      window_len_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_len) begin
      cfg_prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, window_len_r};
    end
  end

  // zero acts as one, anything beyond MAX_WINDOW acts as MAX_WINDOW
  always_comb begin
    len_eff = window_len_r;
    if (window_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(window_len_r) > MAX_WINDOW) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end
  end

endmodule

`default_nettype wire

/* sv/memw_window.sv */
// ----------------------------------------------------------------------------
// memw_window
// Prefix-sum bank: row counters, running prefix sum and energy, and a
// circular memory of past prefixes that yields each window by subtraction.
// ----------------------------------------------------------------------------
`default_nettype none

module memw_window import memw_pkg::*; #(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_acc,
  input  wire memw_in_t         in_word,
  input  wire logic [LEN_W-1:0] len_eff,
  output memw_win_t             win_r
);

  localparam int AW    = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH = 1 << AW;
  localparam int ENT_W = SUM_W + NRG_W;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_r;

  // row state, updated as words are accepted
  logic [SEEN_W-1:0]       seen_r, seen_inc;
  logic signed [TOT_W-1:0] row_tot_r, tot_sat;
  logic                    clip_r, clip_inc;
  logic [AW-1:0]           ptr_r, rd_addr;
  logic signed [TOT_W:0]   tot_ext;
  logic signed [SQ_W-1:0]  sq_full;
  logic                    full_a;

  // running prefixes over everything ever accepted (modular)
  logic signed [SUM_W-1:0] p_run_r, p_after, old_p;
  logic [NRG_W-1:0]        e_run_r, e_after, old_e;

  // second stage
  logic                       b_v_r;
  logic signed [SAMPLE_W-1:0] s_b_r;
  logic [SQ_W-1:0]            sq_b_r;
  logic                       last_b_r, full_b_r, clip_b_r, self_b_r, fwd_b_r;
  logic signed [TOT_W-1:0]    tot_b_r;
  logic [AW-1:0]              ptr_b_r;
  logic [ENT_W-1:0]           fwd_data_b_r, old_ent;
  logic                       b_go;

  assign seen_inc = (seen_r == SEEN_MAX) ? seen_r : seen_r + 1'b1;
  assign full_a   = (seen_inc >= SEEN_W'(len_eff));
  assign tot_ext  = {row_tot_r[TOT_W-1], row_tot_r}
                  + (TOT_W+1)'(in_word.sample);
  assign sq_full  = in_word.sample * in_word.sample;
  // entry holding the prefix just before the oldest sample of the window
  assign rd_addr  = ptr_r - AW'(len_eff) + 1'b1;

  always_comb begin
    tot_sat  = tot_ext[TOT_W-1:0];
    clip_inc = clip_r;
    if (tot_ext[TOT_W] != tot_ext[TOT_W-1]) begin
      tot_sat  = tot_ext[TOT_W] ? TOT_MIN : TOT_MAX;
      clip_inc = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      row_tot_r <= '0;
      clip_r    <= 1'b0;
      ptr_r     <= '0;
    end else if (in_acc) begin
      ptr_r <= ptr_r + 1'b1;
      if (in_word.last_sample) begin
        seen_r    <= '0;
        row_tot_r <= '0;
        clip_r    <= 1'b0;
      end else begin
        seen_r    <= seen_inc;
        row_tot_r <= tot_sat;
        clip_r    <= clip_inc;
      end
    end
  end

  // read port: registered data, taken only with an accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= mem[rd_addr];
    end
  end

  // write port: prefix before this sample, at this sample's slot
  always_ff @(posedge clk) begin
    if (b_go) begin
      mem[ptr_b_r] <= {p_run_r, e_run_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_b_r        <= in_word.sample;
      sq_b_r       <= sq_full[SQ_W-1:0];
      last_b_r     <= in_word.last_sample;
      full_b_r     <= full_a;
      tot_b_r      <= tot_sat;
      clip_b_r     <= clip_inc;
      ptr_b_r      <= ptr_r;
      self_b_r     <= (len_eff == LEN_W'(1));
      // slot being written at this same edge: the read returns stale data
      fwd_b_r      <= b_v_r && (rd_addr == ptr_b_r);
      fwd_data_b_r <= {p_run_r, e_run_r};
    end
  end

  assign b_go = adv && b_v_r;

  always_comb begin
    old_ent = rd_r;
    if (self_b_r) begin
      old_ent = {p_run_r, e_run_r};
    end else if (fwd_b_r) begin
      old_ent = fwd_data_b_r;
    end
  end

  assign old_p   = old_ent[ENT_W-1:NRG_W];
  assign old_e   = old_ent[NRG_W-1:0];
  assign p_after = p_run_r + SUM_W'(s_b_r);
  assign e_after = e_run_r + NRG_W'(sq_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_run_r <= '0;
      e_run_r <= '0;
    end else if (b_go) begin
      p_run_r <= p_after;
      e_run_r <= e_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.vld <= 1'b0;
    end else if (adv) begin
      win_r.vld <= b_v_r;
    end
    if (b_go) begin
      win_r.last       <= last_b_r;
      win_r.full       <= full_b_r;
      win_r.total      <= tot_b_r;
      win_r.clipped    <= clip_b_r;
      win_r.win_sum    <= p_after - old_p;
      win_r.win_energy <= e_after - old_e;
    end
  end

endmodule

`default_nettype wire

/* sv/memw_best.sv */
// ----------------------------------------------------------------------------
// memw_best
// Best-window tracker, end-of-row product with saturation, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module memw_best import memw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire memw_win_t win,
  input  wire logic      out_stall,
  output logic           hold,
  output logic           out_valid,
  output memw_out_t      out_data
);

  logic                    have_r, have_n, better;
  logic [NRG_W-1:0]        best_e_r, best_e_n;
  logic signed [SUM_W-1:0] best_s_r, best_s_n;
  logic                    c_go;

  logic                    op_v_r, op_have_r, op_clip_r;
  logic signed [TOT_W-1:0] op_tot_r;
  logic signed [SUM_W-1:0] op_bs_r;
  logic                    drain;
  logic signed [TOT_W+SUM_W-1:0] prod;
  logic signed [PROD_W-1:0]      prod_sat;

  assign c_go   = adv && win.vld;
  assign better = win.full && (!have_r || (win.win_energy < best_e_r));

  always_comb begin
    have_n   = have_r;
    best_e_n = best_e_r;
    best_s_n = best_s_r;
    if (better) begin
      have_n   = 1'b1;
      best_e_n = win.win_energy;
      best_s_n = win.win_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r   <= 1'b0;
      best_e_r <= '0;
      best_s_r <= '0;
    end else if (c_go) begin
      if (win.last) begin
        have_r   <= 1'b0;
        best_e_r <= '0;
        best_s_r <= '0;
      end else begin
        have_r   <= have_n;
        best_e_r <= best_e_n;
        best_s_r <= best_s_n;
      end
    end
  end

  // row-end operands wait here until the result register is free
  assign drain = op_v_r && (!out_valid || !out_stall);
  assign hold  = op_v_r && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_v_r <= 1'b0;
    end else begin
      op_v_r <= (op_v_r && !drain) || (c_go && win.last);
    end
  end

  always_ff @(posedge clk) begin
    if (c_go && win.last) begin
      op_tot_r  <= win.total;
      op_bs_r   <= best_s_n;
      op_have_r <= have_n;
      op_clip_r <= win.clipped;
    end
  end

  assign prod = op_tot_r * op_bs_r;

  always_comb begin
    prod_sat = prod[PROD_W-1:0];
    if (!op_have_r) begin
      prod_sat = '0;
    end else if ((prod[TOT_W+SUM_W-1:PROD_W-1] != '0) &&
                 (prod[TOT_W+SUM_W-1:PROD_W-1] != '1)) begin
      prod_sat = prod[TOT_W+SUM_W-1] ? PROD_MIN : PROD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data.weighted_total <= prod_sat;
      out_data.window_found   <= op_have_r;
      out_data.sum_saturated  <= op_clip_r;
    end
  end

endmodule

`default_nettype wire

/* sv/min_energy_window_weight_unit.sv */
// ----------------------------------------------------------------------------
// min_energy_window_weight_unit
// Minimum-energy window weighting over rows of signed samples.
// ----------------------------------------------------------------------------
// The unit takes one sample word per clock, back to back, and holds a row
// until the word marked last_sample. For every position where at least
// window_len samples of the row have been seen it forms the window sum and
// energy (sum of squares) of the newest window_len samples; the first window
// of lowest energy wins, a later one only when strictly lower. At the end of
// the row one result word gives the saturated row total times the winning
// window sum (saturated to 47 bits, zero when no full window existed), the
// window_found flag and the sum_saturated flag. Windows come from a circular
// memory of running prefix sums and energies (depth the next power of two
// above MAX_WINDOW, one write and one read port): each window is the current
// prefix minus the stored prefix window_len words back, so a change of
// window_len between words takes effect at the next word. A row's last word
// reaches the result register via the window and operand registers. Input words
// are taken every cycle while the result register is free or being emptied;
// in_stall rises only when a finished result waits in the result register
// with a second one queued behind it. window_len sits at byte address 0 of
// the register port; write it only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module min_energy_window_weight_unit import memw_pkg::*; #(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample words
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire memw_in_t              in_data,
  // result words
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output memw_out_t                  out_data,
  // register port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [LEN_W-1:0] len_eff;
  logic             hold;
  logic             adv;
  logic             in_acc;
  memw_win_t        win;

  // whole pipeline stands still only while a result cannot leave
  assign adv      = !hold;
  assign in_stall = hold;
  assign in_acc   = in_valid && !in_stall;

  memw_cfg #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .len_eff     (len_eff)
  );

  // prefix memory and row counters: accept stage and subtract stage
  memw_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_acc  (in_acc),
    .in_word (in_data),
    .len_eff (len_eff),
    .win_r   (win)
  );

  // compare against the best window, then multiply out at row end
  memw_best u_best (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .win       (win),
    .out_stall (out_stall),
    .hold      (hold),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // stall only ever comes from a full result register
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // no full window means no product
  a_no_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.window_found) |-> (out_data.weighted_total == '0))
    else $error("result without window carries a product");

  // a register write reads back on the following cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
     (cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LEN))
    |=> ((cfg_paddr[CFG_ADDR_W-1:2] != REG_WINDOW_LEN) ||
         (cfg_prdata[LEN_W-1:0] == $past(cfg_pwdata[LEN_W-1:0]))))
    else $error("window length register did not take the write");

endmodule

`default_nettype wire
